// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file gfwd_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/gfwd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfwd_pkg
// Shared types and constants of the gait freeze window detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfwd_pkg;

	localparam int MAX_WINDOW_DEF = 1024;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int MAG_W          = 16;
	localparam int SUM_W          = 26;
	localparam int STEP_W         = 10;
	localparam int WCNT_W         = 8;
	localparam int QUEUE_DEPTH    = 4;
	localparam int ROOT_STEPS     = 16;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH      = 3'd0,
		REG_STEP_THRESHOLD     = 3'd1,
		REG_WALK_THRESHOLD     = 3'd2,
		REG_FREEZE_THRESHOLD   = 3'd3,
		REG_REST_THRESHOLD     = 3'd4,
		REG_MIN_STEPS          = 3'd5,
		REG_MIN_WALK_WINDOWS   = 3'd6,
		REG_MIN_FREEZE_WINDOWS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0]       window_length;
		logic [15:0]       step_threshold;
		logic [15:0]       walk_threshold;
		logic [15:0]       freeze_threshold;
		logic [15:0]       rest_threshold;
		logic [STEP_W-1:0] min_steps;
		logic [WCNT_W-1:0] min_walk_windows;
		logic [WCNT_W-1:0] min_freeze_windows;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		window_length:      11'd156,
		step_threshold:     16'd9830,
		walk_threshold:     16'd2458,
		freeze_threshold:   16'd1966,
		rest_threshold:     16'd819,
		min_steps:          10'd4,
		min_walk_windows:   8'd2,
		min_freeze_windows: 8'd2
	};

	typedef struct packed {
		logic              freeze_detected;
		logic              walking_now;
		logic [STEP_W-1:0] window_steps;
		logic [SUM_W-1:0]  movement_sum;
	} result_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQUARE,
		F_ROOT,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_COMPARE,
		B_DECIDE
	} back_state_t;

endpackage

// ----- rtl/core/gfwd_front.sv -----
// ----------------------------------------------------------------------------
// gfwd_front
// Accepts one sample, sums the three squares with a shared multiplier and
// takes the integer square root one bit pair per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfwd_front import gfwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x_raw,
	input  logic signed [15:0] accel_y_raw,
	input  logic signed [15:0] accel_z_raw,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [MAG_W-1:0]   push_mag
);

	localparam int ITER_W = $clog2(ROOT_STEPS);

	front_state_t state_q, state_d;

	logic [16:0]       a0_q, a1_q, a2_q;
	logic [31:0]       acc_q;
	logic [31:0]       root_q;
	logic [31:0]       bit_q;
	logic [ITER_W-1:0] iter_q;

	logic [33:0] sq;
	logic [31:0] trial;
	logic        take;

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? (~e + 17'd1) : e;
	endfunction

	assign sq    = 34'(a0_q) * 34'(a0_q);
	assign trial = root_q + bit_q;
	assign take  = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = F_SQUARE;
			end
			F_SQUARE: begin
				if (iter_q == ITER_W'(2)) state_d = F_ROOT;
			end
			F_ROOT: begin
				if (iter_q == ITER_W'(ROOT_STEPS - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (take) begin
			iter_q <= '0;
		end else if (state_q == F_SQUARE && iter_q == ITER_W'(2)) begin
			iter_q <= '0;
		end else if (state_q == F_SQUARE || state_q == F_ROOT) begin
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	// Datapath: square sum, then restoring square root
	always_ff @(posedge clk) begin
		if (take) begin
			a0_q  <= abs16(accel_x_raw);
			a1_q  <= abs16(accel_y_raw);
			a2_q  <= abs16(accel_z_raw);
			acc_q <= '0;
		end else if (state_q == F_SQUARE) begin
			acc_q <= acc_q + sq[31:0];
			a0_q  <= a1_q;
			a1_q  <= a2_q;
			root_q <= '0;
			bit_q  <= 32'h4000_0000;
		end else if (state_q == F_ROOT) begin
			if (acc_q >= trial) begin
				acc_q  <= acc_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign push_mag = root_q[MAG_W-1:0];

endmodule

// ----- rtl/core/gfwd_queue.sv -----
// ----------------------------------------------------------------------------
// gfwd_queue
// Short FIFO of sample magnitudes between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfwd_queue import gfwd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [MAG_W-1:0] push_mag,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [MAG_W-1:0] pop_mag
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [MAG_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push, do_pop;

	assign push_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_mag    = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop) fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_mag;
	end

endmodule

// ----- rtl/core/gfwd_back.sv -----
// ----------------------------------------------------------------------------
// gfwd_back
// Window accumulation of magnitude changes, threshold comparison at window
// end and the walking / freeze decision with its output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfwd_back import gfwd_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [MAG_W-1:0] pop_mag,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          result
);

	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int PROD_W = 16 + LEN_W;
	localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

	back_state_t state_q, state_d;

	logic [LEN_W-1:0]  count_q;
	logic [MAG_W-1:0]  prev_q;
	logic [SUM_W-1:0]  sum_q;
	logic [STEP_W-1:0] steps_q;
	logic [WCNT_W-1:0] walk_cnt_q, still_cnt_q;
	logic              was_walking_q, is_walking_q;
	logic [1:0]        sel_q;
	logic              walk_gt_q, freeze_lt_q, rest_lt_q;
	logic              out_valid_q;
	result_t           result_q;

	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  count_inc;
	logic              window_end;
	logic              take;
	logic [MAG_W-1:0]  delta;
	logic [SUM_W:0]    sum_add;
	logic [15:0]       thr;
	logic [PROD_W-1:0] prod;
	logic              emit;

	// Decision outcome
	logic              walk_win, still_win, rest_win;
	logic [WCNT_W-1:0] walk_inc, still_inc;
	logic [WCNT_W-1:0] walk_cnt_d, still_cnt_d;
	logic              was_walking_d, is_walking_d, freeze_d;

	// Window length limited to the legal range
	always_comb begin
		if (32'(cfg.window_length) < 2) begin
			len = LEN_W'(2);
		end else if (32'(cfg.window_length) > MAX_WINDOW) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(cfg.window_length);
		end
	end

	assign count_inc  = count_q + LEN_W'(1);
	assign window_end = (count_inc >= len);
	assign take       = pop_valid && pop_ready;
	assign delta      = (pop_mag >= prev_q) ? (pop_mag - prev_q) : (prev_q - pop_mag);
	assign sum_add    = {1'b0, sum_q} + (SUM_W + 1)'(delta);
	assign emit       = (state_q == B_DECIDE) && (!out_valid_q || out_ready);

	// Threshold times length, one threshold per cycle
	always_comb begin
		case (sel_q)
			2'd0:    thr = cfg.walk_threshold;
			2'd1:    thr = cfg.freeze_threshold;
			default: thr = cfg.rest_threshold;
		endcase
		prod = PROD_W'(thr) * PROD_W'(len);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue handshake
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid && window_end) state_d = B_COMPARE;
			end
			B_COMPARE: begin
				if (sel_q == 2'd2) state_d = B_DECIDE;
			end
			B_DECIDE: begin
				if (!out_valid_q || out_ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Window accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
			sum_q   <= '0;
			steps_q <= '0;
		end else if (take) begin
			prev_q  <= pop_mag;
			count_q <= window_end ? '0 : count_inc;
			if (count_q == '0) begin
				sum_q   <= '0;
				steps_q <= '0;
			end else begin
				sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
				if (delta > cfg.step_threshold && steps_q != {STEP_W{1'b1}}) begin
					steps_q <= steps_q + STEP_W'(1);
				end
			end
		end
	end

	// Comparison sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (state_q == B_COMPARE) begin
			sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_COMPARE) begin
			case (sel_q)
				2'd0:    walk_gt_q   <= CMP_W'(sum_q) > CMP_W'(prod);
				2'd1:    freeze_lt_q <= CMP_W'(sum_q) < CMP_W'(prod);
				default: rest_lt_q   <= CMP_W'(sum_q) < CMP_W'(prod);
			endcase
		end
	end

	// Walking / still / rest decision
	always_comb begin
		walk_win      = (steps_q >= cfg.min_steps) && walk_gt_q;
		still_win     = was_walking_q && freeze_lt_q;
		rest_win      = rest_lt_q;
		walk_inc      = (walk_cnt_q != {WCNT_W{1'b1}}) ? walk_cnt_q + WCNT_W'(1) : walk_cnt_q;
		still_inc     = (still_cnt_q != {WCNT_W{1'b1}}) ? still_cnt_q + WCNT_W'(1)
		                                                 : still_cnt_q;
		walk_cnt_d    = walk_cnt_q;
		still_cnt_d   = still_cnt_q;
		was_walking_d = was_walking_q;
		is_walking_d  = is_walking_q;
		freeze_d      = 1'b0;
		if (walk_win) begin
			walk_cnt_d  = walk_inc;
			still_cnt_d = '0;
			if (walk_inc >= cfg.min_walk_windows) begin
				is_walking_d  = 1'b1;
				was_walking_d = 1'b1;
			end
		end else if (still_win) begin
			still_cnt_d = still_inc;
			walk_cnt_d  = '0;
			if (still_inc >= cfg.min_freeze_windows) begin
				is_walking_d  = 1'b0;
				was_walking_d = 1'b0;
				still_cnt_d   = '0;
				freeze_d      = 1'b1;
			end
		end else if (rest_win) begin
			walk_cnt_d   = '0;
			still_cnt_d  = '0;
			is_walking_d = 1'b0;
		end
	end

	// Detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cnt_q    <= '0;
			still_cnt_q   <= '0;
			was_walking_q <= 1'b0;
			is_walking_q  <= 1'b0;
		end else if (emit) begin
			walk_cnt_q    <= walk_cnt_d;
			still_cnt_q   <= still_cnt_d;
			was_walking_q <= was_walking_d;
			is_walking_q  <= is_walking_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.freeze_detected <= freeze_d;
			result_q.walking_now     <= is_walking_d;
			result_q.window_steps    <= steps_q;
			result_q.movement_sum    <= sum_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ----- rtl/core/gait_freeze_window_detector.sv -----
// Gait freeze window detector.
// Input channel: in_valid/in_ready with one accelerometer sample per
// transaction (accel_x_raw, accel_y_raw, accel_z_raw, signed 16 bit).
// Output channel: out_valid/out_ready with one result per completed window
// (freeze_detected, walking_now, window_steps, movement_sum); samples that
// do not close a window give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no sample is in flight.
// Front: a new sample is accepted only in the idle state; each sample then
// passes the shared squaring multiplier for the three axes, the bit-pair
// square root and a push into the queue, which waits while the queue is full.
// Result path: a window-closing sample leaves the queue and then passes the
// walk, freeze and rest comparisons and the decision step before its result
// is registered in the output register.
// Stall: the result waits in the output register while out_ready is low;
// the back keeps accumulating queued samples and holds only a window end.
// The four-entry queue then fills and in_ready stays low.
// Reset: arst_n clears all counters, the walking and valid flags and the queue
// and loads the default configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
// gait_freeze_window_detector
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gait_freeze_window_detector import gfwd_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    accel_x_raw,
	input  logic signed [15:0]    accel_y_raw,
	input  logic signed [15:0]    accel_z_raw,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  freeze_detected,
	output logic                  walking_now,
	output logic [STEP_W-1:0]     window_steps,
	output logic [SUM_W-1:0]      movement_sum
);

	cfg_t             cfg_q;
	result_t          result;
	logic             push_valid, push_ready;
	logic [MAG_W-1:0] push_mag;
	logic             pop_valid, pop_ready;
	logic [MAG_W-1:0] pop_mag;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LENGTH:      cfg_q.window_length      <= cfg_data[10:0];
				REG_STEP_THRESHOLD:     cfg_q.step_threshold     <= cfg_data;
				REG_WALK_THRESHOLD:     cfg_q.walk_threshold     <= cfg_data;
				REG_FREEZE_THRESHOLD:   cfg_q.freeze_threshold   <= cfg_data;
				REG_REST_THRESHOLD:     cfg_q.rest_threshold     <= cfg_data;
				REG_MIN_STEPS:          cfg_q.min_steps          <= cfg_data[STEP_W-1:0];
				REG_MIN_WALK_WINDOWS:   cfg_q.min_walk_windows   <= cfg_data[WCNT_W-1:0];
				REG_MIN_FREEZE_WINDOWS: cfg_q.min_freeze_windows <= cfg_data[WCNT_W-1:0];
				default: ;
			endcase
		end
	end

	gfwd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.accel_x_raw (accel_x_raw),
		.accel_y_raw (accel_y_raw),
		.accel_z_raw (accel_z_raw),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_mag    (push_mag)
	);

	gfwd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_mag   (push_mag),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_mag    (pop_mag)
	);

	gfwd_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_mag   (pop_mag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign freeze_detected = result.freeze_detected;
	assign walking_now     = result.walking_now;
	assign window_steps    = result.window_steps;
	assign movement_sum    = result.movement_sum;

endmodule

// ----- rtl/core/gfwd_checker.sv -----
// ----------------------------------------------------------------------------
// gfwd_checker
// Port-level checks of the gait freeze window detector, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfwd_checker import gfwd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              freeze_detected,
	input logic              walking_now,
	input logic [STEP_W-1:0] window_steps,
	input logic [SUM_W-1:0]  movement_sum
);

	// A stalled result holds its valid, steps, sum and walking flag
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(window_steps) && $stable(movement_sum) && $stable(walking_now)), "stalled result changed")

	// The front is busy with the squares and the square root after each accepted sample
	`ASSERT_CLK(a_front_busy, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "front accepted back to back")

	// A freeze event always ends the walking state
	`ASSERT_IMPLIES(a_freeze_clears_walk, clk, arst_n, out_valid && freeze_detected, !walking_now, "freeze reported while walking")

endmodule

bind gait_freeze_window_detector gfwd_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.freeze_detected (freeze_detected),
	.walking_now     (walking_now),
	.window_steps    (window_steps),
	.movement_sum    (movement_sum)
);
